[hw/rtl/mbce_pkg.sv]
// shared types, register indexes and color helpers for the monochrome bitmap clip expander
package mbce_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_IMAGE_X     = 3'd0,
        CFG_IMAGE_Y     = 3'd1,
        CFG_BITMAP_SIZE = 3'd2,
        CFG_CLIP_X      = 3'd3,
        CFG_CLIP_Y      = 3'd4,
        CFG_CLIP_W      = 3'd5,
        CFG_CLIP_H      = 3'd6,
        CFG_COLOUR_PAIR = 3'd7
    } cfg_index_t;

    localparam int unsigned CFG_DATA_W = 48;

    // foreground white, background black
    localparam logic [CFG_DATA_W-1:0] COLOUR_PAIR_RESET = 48'hFFFFFF000000;

    // register file as seen by the front end
    typedef struct packed {
        logic signed [15:0] image_x;
        logic signed [15:0] image_y;
        logic        [31:0] bitmap_size;
        logic signed [15:0] clip_x;
        logic signed [15:0] clip_y;
        logic signed [15:0] clip_w;
        logic signed [15:0] clip_h;
    } cfg_t;

    // one classified byte waiting for the back end
    typedef struct packed {
        logic        [7:0]  data;     // raw bitmap byte, msb is leftmost pixel
        logic        [7:0]  emit;     // bit k set: pixel k is visible
        logic        [7:0]  row_end;  // bit k set: pixel k is last visible one of its row
        logic signed [16:0] x_base;   // screen x of pixel 0 of this byte
        logic signed [16:0] sy;       // screen row
    } entry_t;

    // rgb888 to rgb565, bytes swapped
    function automatic logic [15:0] swapped565(input logic [23:0] rgb);
        logic [15:0] p;
        p = {rgb[23:19], rgb[15:10], rgb[7:3]};
        return {p[7:0], p[15:8]};
    endfunction

endpackage

[hw/rtl/mono_bitmap_clip_expander.sv]
// top level of the monochrome bitmap clip expander: config registers, front, queue, back
//
// Expands a 1-bit-per-pixel bitmap, fed one byte per transaction (msb is the leftmost pixel,
// rows padded to whole bytes), into clipped screen pixels. Each visible pixel comes out as one
// output transaction carrying its screen position, the foreground (bit set) or background
// (bit clear) color as byte-swapped RGB565, a row_end flag on the last visible pixel of a row
// and a last flag on the final pixel caused by its byte. Bytes with no visible pixel produce
// nothing but still advance the row and byte counters, which wrap to zero after the last byte
// of the bitmap. Rate: the output register moves one pixel per cycle while out_stall is low;
// the input takes a byte every cycle while the queue has room, and bytes with no visible
// pixel are not queued. A pixel passes the queue, the current-byte register and the output
// register. The front end classifies bytes against the clip window and pushes them into a
// QUEUE_DEPTH entry queue; the back end walks the visible bits. cfg_ready is always high;
// write registers only while the block is idle.
module mono_bitmap_clip_expander #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // bitmap byte input
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     image_byte,
    // pixel output
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [16:0]             screen_x,
    output logic signed [16:0]             screen_y,
    output logic [15:0]                    pixel_word,
    output logic                           row_end,
    output logic                           last,
    // register write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [2:0]                     cfg_index,
    input  logic [mbce_pkg::CFG_DATA_W-1:0] cfg_data
);

    // register file
    mbce_pkg::cfg_t                  cfg_reg, cfg_next;
    logic [mbce_pkg::CFG_DATA_W-1:0] colour_pair_reg, colour_pair_next;
    logic                            cfg_write;

    // front to queue
    logic             q_push;
    mbce_pkg::entry_t q_entry;
    logic             q_full;

    // queue to back
    logic             q_pop;
    logic             q_not_empty;
    mbce_pkg::entry_t q_head;

    // colors in output format
    logic [15:0]      fg_word;
    logic [15:0]      bg_word;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // register decode, signed registers take the low 16 bits of the write data
    always_comb
    begin
        cfg_next         = cfg_reg;
        colour_pair_next = colour_pair_reg;
        if (cfg_write)
        begin
            case (mbce_pkg::cfg_index_t'(cfg_index))
                mbce_pkg::CFG_IMAGE_X:     cfg_next.image_x     = cfg_data[15:0];
                mbce_pkg::CFG_IMAGE_Y:     cfg_next.image_y     = cfg_data[15:0];
                mbce_pkg::CFG_BITMAP_SIZE: cfg_next.bitmap_size = cfg_data[31:0];
                mbce_pkg::CFG_CLIP_X:      cfg_next.clip_x      = cfg_data[15:0];
                mbce_pkg::CFG_CLIP_Y:      cfg_next.clip_y      = cfg_data[15:0];
                mbce_pkg::CFG_CLIP_W:      cfg_next.clip_w      = cfg_data[15:0];
                mbce_pkg::CFG_CLIP_H:      cfg_next.clip_h      = cfg_data[15:0];
                mbce_pkg::CFG_COLOUR_PAIR: colour_pair_next     = cfg_data;
                default:                   cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg         <= '0;
            colour_pair_reg <= mbce_pkg::COLOUR_PAIR_RESET;
        end
        else
        begin
            cfg_reg         <= cfg_next;
            colour_pair_reg <= colour_pair_next;
        end
    end

    // the user must change colors only while idle, the block does not enforce it; the back end reads them directly
    assign fg_word = mbce_pkg::swapped565(colour_pair_reg[47:24]);
    assign bg_word = mbce_pkg::swapped565(colour_pair_reg[23:0]);

    mbce_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .image_byte (image_byte),
        .cfg        (cfg_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (q_entry)
    );

    mbce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    mbce_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .fg_word     (fg_word),
        .bg_word     (bg_word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .screen_x    (screen_x),
        .screen_y    (screen_y),
        .pixel_word  (pixel_word),
        .row_end     (row_end),
        .last        (last)
    );

endmodule

[hw/rtl/mbce_front.sv]
// front end: byte and row counters, clip classification of each incoming byte
module mbce_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            image_byte,
    input  mbce_pkg::cfg_t        cfg,
    input  logic                  q_full,
    output logic                  q_push,
    output mbce_pkg::entry_t      q_entry
);

    logic [15:0]        row_index_reg, row_index_next;
    logic [12:0]        byte_index_reg, byte_index_next;

    logic [15:0]        width;
    logic [15:0]        height;
    logic [16:0]        width_pad;
    logic [13:0]        stride;
    logic [13:0]        byte_inc;
    logic [16:0]        row_inc;
    logic               accept;
    logic               empty_bitmap;
    logic               in_range;
    logic signed [17:0] sy;
    logic signed [17:0] clip_y_w;
    logic signed [17:0] clip_y_end;
    logic signed [17:0] image_x_w;
    logic signed [17:0] clip_x_w;
    logic signed [17:0] clip_x_end;
    logic signed [17:0] image_x_end;
    logic signed [17:0] x0;
    logic signed [17:0] x1;
    logic signed [17:0] x1_last;
    logic               row_ok;
    logic               visible;
    logic [7:0]         emit_mask;
    logic [7:0]         end_mask;
    logic signed [17:0] col [8];

    assign width        = cfg.bitmap_size[31:16];
    assign height       = cfg.bitmap_size[15:0];
    assign width_pad    = {1'b0, width} + 17'd7;
    assign stride       = width_pad[16:3];
    assign empty_bitmap = (width == 16'd0) || (height == 16'd0);
    assign in_range     = ({1'b0, row_index_reg} < {1'b0, height})
                          && ({1'b0, byte_index_reg} < stride);

    // vertical clip
    assign sy         = 18'(cfg.image_y) + $signed({2'b00, row_index_reg});
    assign clip_y_w   = 18'(cfg.clip_y);
    assign clip_y_end = 18'(cfg.clip_y) + 18'(cfg.clip_h);
    assign row_ok     = (sy >= clip_y_w) && (sy < clip_y_end);

    // horizontal clip, visible columns are [x0,x1)
    assign image_x_w   = 18'(cfg.image_x);
    assign clip_x_w    = 18'(cfg.clip_x);
    assign clip_x_end  = 18'(cfg.clip_x) + 18'(cfg.clip_w);
    assign image_x_end = image_x_w + $signed({2'b00, width});
    assign x0          = (image_x_w >= clip_x_w) ? 18'sd0 : (clip_x_w - image_x_w);
    assign x1          = (image_x_end > clip_x_end) ? (clip_x_end - image_x_w)
                                                    : $signed({2'b00, width});
    assign x1_last     = x1 - 18'sd1;

    assign visible = !empty_bitmap && in_range && row_ok && (x0 < x1);

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            col[k]       = $signed({2'b00, byte_index_reg, 3'(k)});
            emit_mask[k] = visible && (col[k] >= x0) && (col[k] < x1);
            end_mask[k]  = (col[k] == x1_last);
        end
    end

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept && (emit_mask != 8'd0);

    assign q_entry.data    = image_byte;
    assign q_entry.emit    = emit_mask;
    assign q_entry.row_end = end_mask;
    assign q_entry.x_base  = 17'(cfg.image_x) + $signed({1'b0, byte_index_reg, 3'b000});
    assign q_entry.sy      = sy[16:0];

    // counter advance
    assign byte_inc = {1'b0, byte_index_reg} + 14'd1;
    assign row_inc  = {1'b0, row_index_reg} + 17'd1;

    always_comb
    begin
        row_index_next  = row_index_reg;
        byte_index_next = byte_index_reg;
        if (accept)
        begin
            if (empty_bitmap)
            begin
                row_index_next  = '0;
                byte_index_next = '0;
            end
            else if (byte_inc >= stride)
            begin
                byte_index_next = '0;
                row_index_next  = (row_inc >= {1'b0, height}) ? 16'd0 : row_inc[15:0];
            end
            else
            begin
                byte_index_next = byte_inc[12:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_index_reg  <= '0;
            byte_index_reg <= '0;
        end
        else
        begin
            row_index_reg  <= row_index_next;
            byte_index_reg <= byte_index_next;
        end
    end

endmodule

[hw/rtl/mbce_queue.sv]
// short fifo of classified bytes between front and back end
module mbce_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mbce_pkg::entry_t push_entry,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output mbce_pkg::entry_t head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    mbce_pkg::entry_t   slots [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slots[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("push into full queue");

endmodule

[hw/rtl/mbce_back.sv]
// back end: walks the visible pixels of each queued byte into the output register, one per cycle unless stalled
module mbce_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_not_empty,
    input  mbce_pkg::entry_t         q_head,
    output logic                     q_pop,
    input  logic [15:0]              fg_word,
    input  logic [15:0]              bg_word,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [16:0]       screen_x,
    output logic signed [16:0]       screen_y,
    output logic [15:0]              pixel_word,
    output logic                     row_end,
    output logic                     last
);

    logic               cur_valid_reg, cur_valid_next;
    mbce_pkg::entry_t   cur_reg;
    logic [7:0]         rem_reg, rem_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [16:0] screen_x_reg;
    logic signed [16:0] screen_y_reg;
    logic [15:0]        pixel_word_reg;
    logic               row_end_reg;
    logic               last_reg;

    logic               out_free;
    logic               emit;
    logic               fin;
    logic [7:0]         pick;
    logic [7:0]         rem_left;
    logic [2:0]         k;

    // lowest remaining pixel goes first
    assign pick     = rem_reg & (~rem_reg + 8'd1);
    assign rem_left = rem_reg & ~pick;

    always_comb
    begin
        k = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (rem_reg[i])
            begin
                k = 3'(i);
            end
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign emit     = cur_valid_reg && out_free;
    assign fin      = emit && (rem_left == 8'd0);
    assign q_pop    = q_not_empty && (!cur_valid_reg || fin);

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        rem_next       = rem_reg;
        if (q_pop)
        begin
            cur_valid_next = 1'b1;
            rem_next       = q_head.emit;
        end
        else if (fin)
        begin
            cur_valid_next = 1'b0;
            rem_next       = 8'd0;
        end
        else if (emit)
        begin
            rem_next = rem_left;
        end
    end

    assign out_valid_next = out_free ? emit : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_head;
        end
        if (emit)
        begin
            screen_x_reg   <= cur_reg.x_base + $signed({14'd0, k});
            screen_y_reg   <= cur_reg.sy;
            pixel_word_reg <= cur_reg.data[3'd7 - k] ? fg_word : bg_word;
            row_end_reg    <= cur_reg.row_end[k];
            last_reg       <= (rem_left == 8'd0);
        end
    end

    assign out_valid  = out_valid_reg;
    assign screen_x   = screen_x_reg;
    assign screen_y   = screen_y_reg;
    assign pixel_word = pixel_word_reg;
    assign row_end    = row_end_reg;
    assign last       = last_reg;

    assert property (@(posedge clk) disable iff (!rst_n) cur_valid_reg |-> (rem_reg != 8'd0))
        else $error("active byte with no pixels left");
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !fin) |=> (cur_valid_reg && (rem_reg == $past(rem_left))))
        else $error("pixel walk skipped or repeated a pixel");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !last_reg) |=> out_valid_reg)
        else $error("gap inside the pixels of one byte");

endmodule

[tb/mbce_checker.sv]
// pixel checker for the bitmap clip expander: tracks registers and counters, predicts, compares
module mbce_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [7:0]                      image_byte,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic signed [16:0]              screen_x,
    input  logic signed [16:0]              screen_y,
    input  logic [15:0]                     pixel_word,
    input  logic                            row_end,
    input  logic                            last,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [2:0]                      cfg_index,
    input  logic [mbce_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            run_done,
    output int                              mismatches,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [16:0] col_x;
        logic signed [16:0] row_y;
        logic        [15:0] word;
        logic               at_row_end;
        logic               ends_byte;
    } pixel_t;

    pixel_t pixels_due[$];
    int     err_count = 0;

    logic signed [15:0]  img_x = '0;
    logic signed [15:0]  img_y = '0;
    logic signed [15:0]  clp_x = '0;
    logic signed [15:0]  clp_y = '0;
    logic signed [15:0]  clp_w = '0;
    logic signed [15:0]  clp_h = '0;
    logic        [31:0]  size_reg = '0;
    logic        [47:0]  colour_reg = mbce_pkg::COLOUR_PAIR_RESET;
    int                  row_pos = 0;
    int                  byte_pos = 0;

    assign mismatches = err_count;

    task automatic report(input string what);
        if (err_count < 40)
        begin
            $display("%0t ns mismatch: %s", $time, what);
        end
        err_count++;
    endtask

    // low byte of the rgb565 word goes out first
    function automatic logic [15:0] to_panel_565(input logic [23:0] rgb);
        logic [4:0] r5;
        logic [5:0] g6;
        logic [4:0] b5;
        r5 = rgb[23:19];
        g6 = rgb[15:10];
        b5 = rgb[7:3];
        return {g6[2:0], b5, r5, g6[5:3]};
    endfunction

    // queue the pixels one bitmap byte produces, then step the row and byte counters
    function automatic void expand_byte(input logic [7:0] bits);
        int width;
        int height;
        int stride;
        int sy;
        int x0;
        int x1;
        int lo;
        int hi;
        int col;
        pixel_t px;
        width  = int'(size_reg[31:16]);
        height = int'(size_reg[15:0]);
        stride = (width + 7) / 8;
        if (width == 0 || height == 0)
        begin
            row_pos  = 0;
            byte_pos = 0;
            return;
        end
        if (row_pos < height && byte_pos < stride)
        begin
            sy = int'(img_y) + row_pos;
            x0 = (img_x >= clp_x) ? 0 : int'(clp_x) - int'(img_x);
            x1 = width;
            if (int'(img_x) + width > int'(clp_x) + int'(clp_w))
            begin
                x1 = int'(clp_x) + int'(clp_w) - int'(img_x);
            end
            // visible columns of this byte; empty when the window misses it
            lo = (byte_pos * 8 > x0) ? byte_pos * 8 : x0;
            hi = (byte_pos * 8 + 7 < x1 - 1) ? byte_pos * 8 + 7 : x1 - 1;
            if (sy >= int'(clp_y) && sy < int'(clp_y) + int'(clp_h))
            begin
                for (col = lo; col <= hi; col++)
                begin
                    px.col_x      = 17'(int'(img_x) + col);
                    px.row_y      = 17'(sy);
                    px.word       = bits[7 - (col - byte_pos * 8)] ?
                                    to_panel_565(colour_reg[47:24]) :
                                    to_panel_565(colour_reg[23:0]);
                    px.at_row_end = (col == x1 - 1);
                    px.ends_byte  = (col == hi);
                    pixels_due.push_back(px);
                end
            end
        end
        byte_pos++;
        if (byte_pos >= stride)
        begin
            byte_pos = 0;
            row_pos++;
            if (row_pos >= height)
            begin
                row_pos = 0;
            end
        end
        byte_pos &= 32'h1FFF;
        row_pos  &= 32'hFFFF;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        pixel_t want;
        if (!rst_n)
        begin
            pixels_due.delete();
            img_x      = '0;
            img_y      = '0;
            clp_x      = '0;
            clp_y      = '0;
            clp_w      = '0;
            clp_h      = '0;
            size_reg   = '0;
            colour_reg = mbce_pkg::COLOUR_PAIR_RESET;
            row_pos    = 0;
            byte_pos   = 0;
            pending   <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    mbce_pkg::CFG_IMAGE_X:     img_x = cfg_data[15:0];
                    mbce_pkg::CFG_IMAGE_Y:     img_y = cfg_data[15:0];
                    mbce_pkg::CFG_BITMAP_SIZE: size_reg = cfg_data[31:0];
                    mbce_pkg::CFG_CLIP_X:      clp_x = cfg_data[15:0];
                    mbce_pkg::CFG_CLIP_Y:      clp_y = cfg_data[15:0];
                    mbce_pkg::CFG_CLIP_W:      clp_w = cfg_data[15:0];
                    mbce_pkg::CFG_CLIP_H:      clp_h = cfg_data[15:0];
                    mbce_pkg::CFG_COLOUR_PAIR: colour_reg = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                expand_byte(image_byte);
            end
            if (out_valid && !out_stall)
            begin
                if (pixels_due.size() == 0)
                begin
                    report($sformatf("unexpected pixel at (%0d,%0d)", screen_x, screen_y));
                end
                else
                begin
                    want = pixels_due.pop_front();
                    if (screen_x !== want.col_x)
                        report($sformatf("screen_x %0d, expected %0d", screen_x, want.col_x));
                    if (screen_y !== want.row_y)
                        report($sformatf("screen_y %0d, expected %0d", screen_y, want.row_y));
                    if (pixel_word !== want.word)
                        report($sformatf("pixel_word %h, expected %h", pixel_word, want.word));
                    if (row_end !== want.at_row_end)
                        report($sformatf("row_end %b, expected %b at (%0d,%0d)",
                                         row_end, want.at_row_end, want.col_x, want.row_y));
                    if (last !== want.ends_byte)
                        report($sformatf("last %b, expected %b at (%0d,%0d)",
                                         last, want.ends_byte, want.col_x, want.row_y));
                end
            end
            pending <= pixels_due.size();
        end
    end

    // anything still queued once stimulus is over never showed up
    always @(posedge run_done)
    begin
        if (pixels_due.size() != 0)
        begin
            report($sformatf("%0d expected pixels never came out", pixels_due.size()));
        end
    end

endmodule

[tb/tb_mono_bitmap_clip_expander.sv]
// testbench top for the bitmap clip expander: clock, reset, stimulus, stalls and the verdict
module tb_mono_bitmap_clip_expander;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES  = 420;   // random bitmap bytes that reach the counters
    localparam int SETTLE_CYCLES = 16;    // queue depth plus pipeline, with margin
    localparam int HOLD_CYCLES   = 200;   // long output hold to back up the queue
    localparam int QUIET_LIMIT   = 1500;  // cycles with no transaction before giving up

    logic                            clk;
    logic                            rst_n      = 1'b0;
    logic                            in_valid   = 1'b0;
    logic                            in_stall;
    logic [7:0]                      image_byte = '0;
    logic                            out_valid;
    logic                            out_stall  = 1'b0;
    logic signed [16:0]              screen_x;
    logic signed [16:0]              screen_y;
    logic [15:0]                     pixel_word;
    logic                            row_end;
    logic                            last;
    logic                            cfg_valid  = 1'b0;
    logic                            cfg_ready;
    logic [2:0]                      cfg_index  = '0;
    logic [mbce_pkg::CFG_DATA_W-1:0] cfg_data   = '0;
    logic                            run_done   = 1'b0;

    int mismatches;
    int pending;

    // run bookkeeping for the watchdog and the closing summary
    int  quiet_cycles = 0;
    int  bytes_in     = 0;
    int  pixels_out   = 0;
    int  row_ends     = 0;
    int  settings     = 0;

    // calm: both sides stop idling for a stretch; hold_req: ask the receiver for a long hold
    bit  calm     = 1'b0;
    bit  hold_req = 1'b0;

    mono_bitmap_clip_expander dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .image_byte (image_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .screen_x   (screen_x),
        .screen_y   (screen_y),
        .pixel_word (pixel_word),
        .row_end    (row_end),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    mbce_checker pixel_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .image_byte (image_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .screen_x   (screen_x),
        .screen_y   (screen_y),
        .pixel_word (pixel_word),
        .row_end    (row_end),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .run_done   (run_done),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // 8 ns clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // pixel receiver: random stalls, quiet during the calm stretch, and a long hold on request;
    // the hold is counted down here so the sender keeps pushing while the block backs up
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (calm)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < 23);
            end
        end
    end

    // watchdog on transactions of any kind, plus counters for the summary
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
            bytes_in <= bytes_in + 1;
        if (out_valid && !out_stall)
        begin
            pixels_out <= pixels_out + 1;
            if (row_end)
                row_ends <= row_ends + 1;
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("no transaction for %0d cycles", QUIET_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int rand_s16();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    // one register transaction; valid stays up when another write follows
    task automatic write_reg(input mbce_pkg::cfg_index_t idx, input logic [47:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // program the whole window; unused upper data bits carry junk the block must ignore
    task automatic load_window(input int ix, input int iy, input logic [31:0] size,
                               input int cx, input int cy, input int cw, input int ch,
                               input logic [47:0] colours);
        write_reg(mbce_pkg::CFG_IMAGE_X,     {32'($urandom), 16'(ix)});
        write_reg(mbce_pkg::CFG_IMAGE_Y,     {32'($urandom), 16'(iy)});
        write_reg(mbce_pkg::CFG_BITMAP_SIZE, {16'($urandom), size});
        write_reg(mbce_pkg::CFG_CLIP_X,      {32'($urandom), 16'(cx)});
        write_reg(mbce_pkg::CFG_CLIP_Y,      {32'($urandom), 16'(cy)});
        write_reg(mbce_pkg::CFG_CLIP_W,      {32'($urandom), 16'(cw)});
        write_reg(mbce_pkg::CFG_CLIP_H,      {32'($urandom), 16'(ch)});
        write_reg(mbce_pkg::CFG_COLOUR_PAIR, colours);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // offer one bitmap byte after a random number of idle cycles, return once taken;
    // valid is left high so back-to-back bytes need no extra edge
    task automatic send_byte(input logic [7:0] value);
        while (!calm && $urandom_range(99) < 23)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        image_byte <= value;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // drop valid, wait for every predicted pixel, then let bytes with no pixels drain too;
    // the first edge lets the last byte's predictions reach the pending count
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int          sent;
        int          phase;
        int          nbytes;
        int          roll;
        int          wd;
        int          ht;
        int          ix;
        int          iy;
        int          cx;
        int          cy;
        int          cw;
        int          ch;
        int          stride;
        logic [47:0] colours;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero width straight out of reset: bytes are swallowed, counters stay put
        send_byte(8'h00);
        send_byte(8'hFF);
        settle();

        // zero height
        load_window(0, 0, {16'd8, 16'd0}, 0, 0, 100, 100, 48'hFFFFFF_000000);
        send_byte(8'hA5);
        settle();

        // 10 wide bitmap: only the middle row is in the window, columns 2..7 survive,
        // the second byte of each row holds only clipped and padding bits
        load_window(5, 2, {16'd10, 16'd3}, 7, 3, 6, 1, 48'h123456_ABCDEF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hAA);
        send_byte(8'h55);
        send_byte(8'h80);
        send_byte(8'h01);
        settle();

        // positive extremes: screen coordinates run past 16 bits
        load_window(32767, 32767, {16'd16, 16'd2}, 32767, 32767, 32767, 2, 48'hFFFFFF_FFFFFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h0F);
        send_byte(8'hF0);
        settle();

        // negative extremes with the largest bitmap: right edge clipped to 8 columns
        load_window(-32768, -32768, 32'hFFFF_FFFF, -32768, -32768, 8, 32767, 48'h000000_FFFFFF);
        send_byte(8'h81);
        send_byte(8'h7E);
        send_byte(8'hC3);
        settle();

        // shrink the bitmap under a byte counter that is now past the row: first byte is
        // dropped and wraps the counter, left edge clipped by three columns after that
        load_window(-3, 0, {16'd16, 16'd4}, 0, -5, 32767, 20, 48'h00FF00_FF00FF);
        send_byte(8'hE7);
        send_byte(8'h3C);
        send_byte(8'h99);
        settle();

        // row counter beyond the new height, then a negative clip width leaves no columns
        load_window(0, 0, {16'd8, 16'd1}, 0, 0, -1, 4, 48'h808080_7F7F7F);
        send_byte(8'hFF);
        send_byte(8'h6D);
        settle();

        // random windows; most phases walk whole bitmaps, the rest stop partway so that
        // the next window starts with stale counters
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_BYTES)
        begin
            calm = (phase >= 12 && phase < 18);
            if (phase == 4)
            begin
                // fully visible 32x4 bitmap while the receiver holds off for a long time
                load_window(0, 0, {16'd32, 16'd4}, 0, 0, 32, 4, {16'($urandom), 32'($urandom)});
                hold_req = 1'b1;
                wd       = 32;
                ht       = 4;
                nbytes   = 16;
            end
            else
            begin
                roll = $urandom_range(99);
                wd   = (roll < 88) ? $urandom_range(40, 1) :
                       (roll < 94) ? 0 : $urandom_range(65535, 41);
                roll = $urandom_range(99);
                ht   = (roll < 85) ? $urandom_range(5, 1) :
                       (roll < 91) ? 0 : $urandom_range(65535, 6);
                ix   = ($urandom_range(99) < 85) ? int'($urandom_range(80)) - 40 : rand_s16();
                iy   = ($urandom_range(99) < 85) ? int'($urandom_range(40)) - 20 : rand_s16();
                cx   = ($urandom_range(99) < 85) ? ix + int'($urandom_range(24)) - 12 : rand_s16();
                cy   = ($urandom_range(99) < 85) ? iy + int'($urandom_range(6)) - 3 : rand_s16();
                roll = $urandom_range(99);
                cw   = (roll < 75) ? int'($urandom_range(50)) :
                       (roll < 88) ? -int'($urandom_range(20, 1)) : rand_s16();
                roll = $urandom_range(99);
                ch   = (roll < 75) ? int'($urandom_range(8, 1)) :
                       (roll < 88) ? -int'($urandom_range(3)) : rand_s16();
                roll = $urandom_range(99);
                colours = (roll < 10) ? '1 : (roll < 20) ? '0 : {16'($urandom), 32'($urandom)};
                load_window(ix, iy, {16'(wd), 16'(ht)}, cx, cy, cw, ch, colours);

                stride = (wd + 7) / 8;
                if (stride * ht == 0)
                    nbytes = $urandom_range(6, 1);
                else if (stride * ht <= 30 && $urandom_range(99) < 75)
                    nbytes = stride * ht * $urandom_range(2, 1);
                else
                    nbytes = $urandom_range(12, 1);
            end

            repeat (nbytes) send_byte(8'($urandom));
            // bytes of an empty bitmap do nothing but clear the counters
            if (wd != 0 && ht != 0)
                sent += nbytes;
            settle();
            phase++;
        end
        calm = 1'b0;

        // all bytes are in and every predicted pixel has arrived; close out the checker
        run_done <= 1'b1;
        repeat (2) @(posedge clk);

        $display("covered %0d bitmap bytes under %0d window setups, one long output hold",
                 bytes_in, settings);
        $display("compared %0d pixels, %0d of them closing a visible row", pixels_out, row_ends);
        if (mismatches == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
